// ===== rtl/core/fwpi_pkg.sv =====
// Package for the four-wheel PI speed controller: widths, register reset
// values and the configuration register index codes. No dependencies.
package fwpi_pkg;

    localparam int NUM_WHEELS = 4;

    localparam int SP_W       = 12;
    localparam int PULSE_W    = 12;
    localparam int DUTY_W     = 16;
    localparam int GAIN_W     = 20;
    localparam int UPPER_W    = 15;
    localparam int INTEG_W    = 16;
    localparam int OFFSET_W   = 12;
    localparam int SCALE_W    = 8;
    localparam int CAP_W      = 16;
    localparam int SPEED_W    = PULSE_W + SCALE_W;   // raw pulses * scale
    localparam int ERR_W      = CAP_W + 2;           // setpoint - capped speed, signed
    localparam int EMAG_W     = ERR_W - 1;
    localparam int ACC_W      = ERR_W + 1;           // integral + error before clamp
    localparam int PPROD_W    = GAIN_W + EMAG_W;
    localparam int PMAG_W     = PPROD_W - 16;
    localparam int PTERM_W    = PMAG_W + 1;
    localparam int IPROD_W    = GAIN_W + INTEG_W;
    localparam int IMAG_W     = IPROD_W - 16;
    localparam int ITERM_W    = IMAG_W + 1;
    localparam int SUM_W      = 24;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;

    localparam logic [GAIN_W-1:0]          PROP_GAIN_RST   = 20'd65536;
    localparam logic [GAIN_W-1:0]          INTEG_GAIN_RST  = 20'd13108;
    localparam logic [UPPER_W-1:0]         INTEG_UPPER_RST = 15'd3000;
    localparam logic signed [INTEG_W-1:0]  INTEG_LOWER_RST = -16'sd500;
    localparam logic [OFFSET_W-1:0]        FF_OFFSET_RST   = 12'd200;
    localparam logic [SCALE_W-1:0]         PULSE_SCALE_RST = 8'd60;
    localparam logic [CAP_W-1:0]           SPEED_CAP_RST   = 16'd800;
    localparam logic [DUTY_W-1:0]          DUTY_MAX_RST    = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 4'd0,
        CFG_INTEG_GAIN  = 4'd1,
        CFG_INTEG_UPPER = 4'd2,
        CFG_INTEG_LOWER = 4'd3,
        CFG_FF_OFFSET   = 4'd4,
        CFG_PULSE_SCALE = 4'd5,
        CFG_SPEED_CAP   = 4'd6,
        CFG_DUTY_MAX    = 4'd7
    } cfg_idx_t;

endpackage

// ===== rtl/core/four_wheel_pi_speed_control.sv =====
// Four-wheel PI speed controller, top level and only module.
// Depends on fwpi_pkg.

// One input transaction is one control period; it yields one result with a
// duty value per wheel. The datapath is a five-register pipeline: input
// register, speed/error stage, integral update plus proportional product,
// integral product, and the output register with the final sum and clamp.
// A new input is accepted every cycle unless every stage is full and the
// output waits on m_ready; the per-wheel integral recurrence closes inside
// the single integral-update stage. Each stage holds its item while the next
// one is full, so bubbles fill even while the output waits on m_ready.
// Configuration writes are taken every cycle and must only happen while the
// pipeline is empty; an index of 8 or more is ignored.
module four_wheel_pi_speed_control (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fwpi_pkg::SP_W-1:0]         s_setpoint_rpm,
    input  logic [fwpi_pkg::PULSE_W-1:0]      s_pulses_w0,
    input  logic [fwpi_pkg::PULSE_W-1:0]      s_pulses_w1,
    input  logic [fwpi_pkg::PULSE_W-1:0]      s_pulses_w2,
    input  logic [fwpi_pkg::PULSE_W-1:0]      s_pulses_w3,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fwpi_pkg::DUTY_W-1:0]       m_duty_w0,
    output logic [fwpi_pkg::DUTY_W-1:0]       m_duty_w1,
    output logic [fwpi_pkg::DUTY_W-1:0]       m_duty_w2,
    output logic [fwpi_pkg::DUTY_W-1:0]       m_duty_w3,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fwpi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fwpi_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fwpi_pkg::*;

    // ---------------- configuration registers ----------------
    logic [GAIN_W-1:0]          prop_gain_reg;
    logic [GAIN_W-1:0]          integ_gain_reg;
    logic [UPPER_W-1:0]         integ_upper_reg;
    logic signed [INTEG_W-1:0]  integ_lower_reg;
    logic [OFFSET_W-1:0]        ff_offset_reg;
    logic [SCALE_W-1:0]         pulse_scale_reg;
    logic [CAP_W-1:0]           speed_cap_reg;
    logic [DUTY_W-1:0]          duty_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
            integ_upper_reg <= INTEG_UPPER_RST;
            integ_lower_reg <= INTEG_LOWER_RST;
            ff_offset_reg   <= FF_OFFSET_RST;
            pulse_scale_reg <= PULSE_SCALE_RST;
            speed_cap_reg   <= SPEED_CAP_RST;
            duty_max_reg    <= DUTY_MAX_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PROP_GAIN:   prop_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  integ_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_UPPER: integ_upper_reg <= cfg_data[UPPER_W-1:0];
                CFG_INTEG_LOWER: integ_lower_reg <= signed'(cfg_data[INTEG_W-1:0]);
                CFG_FF_OFFSET:   ff_offset_reg   <= cfg_data[OFFSET_W-1:0];
                CFG_PULSE_SCALE: pulse_scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_SPEED_CAP:   speed_cap_reg   <= cfg_data[CAP_W-1:0];
                CFG_DUTY_MAX:    duty_max_reg    <= cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic v0_next, v1_next, v2_next, v3_next, m_valid_next;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic ld0, ld1, ld2, ld3, ld4;

    always_comb begin
        rdy4 = !m_valid_reg || m_ready;
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
        rdy0 = !v0_reg || rdy1;
        ld0  = s_valid && rdy0;
        ld1  = v0_reg && rdy1;
        ld2  = v1_reg && rdy2;
        ld3  = v2_reg && rdy3;
        ld4  = v3_reg && rdy4;
        v0_next      = rdy0 ? s_valid : v0_reg;
        v1_next      = rdy1 ? v0_reg  : v1_reg;
        v2_next      = rdy2 ? v1_reg  : v2_reg;
        v3_next      = rdy3 ? v2_reg  : v3_reg;
        m_valid_next = rdy4 ? v3_reg  : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v0_reg      <= v0_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = rdy0;
    assign m_valid = m_valid_reg;

    // ---------------- stage 0: input register ----------------
    logic [PULSE_W-1:0] pulses_in [NUM_WHEELS];
    logic [SP_W-1:0]    sp0_reg;
    logic [PULSE_W-1:0] pulses0_reg [NUM_WHEELS];

    assign pulses_in[0] = s_pulses_w0;
    assign pulses_in[1] = s_pulses_w1;
    assign pulses_in[2] = s_pulses_w2;
    assign pulses_in[3] = s_pulses_w3;

    always_ff @(posedge aclk) begin
        if (ld0) begin
            sp0_reg     <= s_setpoint_rpm;
            pulses0_reg <= pulses_in;
        end
    end

    // ---------------- stage 1: speed and error ----------------
    logic [SPEED_W-1:0]       speed_raw [NUM_WHEELS];
    logic [CAP_W-1:0]         speed_lim [NUM_WHEELS];
    logic signed [ERR_W-1:0]  err_calc  [NUM_WHEELS];
    logic signed [ERR_W-1:0]  err1_reg  [NUM_WHEELS];
    logic [SP_W-1:0]          sp1_reg;
    logic                     stop1_reg;

    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            speed_raw[w] = SPEED_W'(pulses0_reg[w]) * SPEED_W'(pulse_scale_reg);
            speed_lim[w] = (speed_raw[w] > SPEED_W'(speed_cap_reg))
                         ? speed_cap_reg : speed_raw[w][CAP_W-1:0];
            err_calc[w]  = signed'(ERR_W'(sp0_reg)) - signed'(ERR_W'(speed_lim[w]));
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            err1_reg  <= err_calc;
            sp1_reg   <= sp0_reg;
            stop1_reg <= (sp0_reg == '0);
        end
    end

    // ---------------- stage 2: integral update, proportional product ----------------
    logic signed [INTEG_W-1:0] integ_reg  [NUM_WHEELS];
    logic signed [INTEG_W-1:0] integ_next [NUM_WHEELS];
    logic signed [ACC_W-1:0]   acc_sum    [NUM_WHEELS];
    logic signed [ACC_W-1:0]   acc_hi     [NUM_WHEELS];
    logic signed [ACC_W-1:0]   acc_lo     [NUM_WHEELS];
    logic signed [ACC_W-1:0]   upper_ext;
    logic signed [ACC_W-1:0]   lower_ext;
    logic [EMAG_W-1:0]         err_mag    [NUM_WHEELS];
    logic [PPROD_W-1:0]        p_prod     [NUM_WHEELS];
    logic signed [PTERM_W-1:0] p_term     [NUM_WHEELS];
    logic signed [PTERM_W-1:0] p2_reg     [NUM_WHEELS];
    logic signed [INTEG_W-1:0] acc2_reg   [NUM_WHEELS];
    logic [SP_W-1:0]           sp2_reg;
    logic                      stop2_reg;

    always_comb begin
        upper_ext = signed'(ACC_W'(integ_upper_reg));
        lower_ext = ACC_W'(integ_lower_reg);
        for (int w = 0; w < NUM_WHEELS; w++) begin
            acc_sum[w] = ACC_W'(integ_reg[w]) + ACC_W'(err1_reg[w]);
            // upper limit first, then lower: a crossed pair ends at the lower bound
            acc_hi[w]  = (acc_sum[w] > upper_ext) ? upper_ext : acc_sum[w];
            acc_lo[w]  = (acc_hi[w] < lower_ext) ? lower_ext : acc_hi[w];
            integ_next[w] = stop1_reg ? '0 : acc_lo[w][INTEG_W-1:0];

            err_mag[w] = err1_reg[w][ERR_W-1] ? EMAG_W'(-err1_reg[w])
                                              : EMAG_W'(err1_reg[w]);
            p_prod[w]  = PPROD_W'(prop_gain_reg) * PPROD_W'(err_mag[w]);
            p_term[w]  = err1_reg[w][ERR_W-1]
                       ? -signed'(PTERM_W'(p_prod[w][PPROD_W-1:16]))
                       :  signed'(PTERM_W'(p_prod[w][PPROD_W-1:16]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < NUM_WHEELS; w++) begin
                integ_reg[w] <= '0;
            end
        end else if (ld2) begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld2) begin
            acc2_reg  <= integ_next;
            p2_reg    <= p_term;
            sp2_reg   <= sp1_reg;
            stop2_reg <= stop1_reg;
        end
    end

    // ---------------- stage 3: integral product ----------------
    logic [INTEG_W-1:0]        acc_mag [NUM_WHEELS];
    logic [IPROD_W-1:0]        i_prod  [NUM_WHEELS];
    logic signed [ITERM_W-1:0] i_term  [NUM_WHEELS];
    logic signed [ITERM_W-1:0] i3_reg  [NUM_WHEELS];
    logic signed [PTERM_W-1:0] p3_reg  [NUM_WHEELS];
    logic [SP_W-1:0]           sp3_reg;
    logic                      stop3_reg;

    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            // -32768 negates to 0x8000, which is right as an unsigned magnitude
            acc_mag[w] = acc2_reg[w][INTEG_W-1] ? INTEG_W'(-acc2_reg[w])
                                                : INTEG_W'(acc2_reg[w]);
            i_prod[w]  = IPROD_W'(integ_gain_reg) * IPROD_W'(acc_mag[w]);
            i_term[w]  = acc2_reg[w][INTEG_W-1]
                       ? -signed'(ITERM_W'(i_prod[w][IPROD_W-1:16]))
                       :  signed'(ITERM_W'(i_prod[w][IPROD_W-1:16]));
        end
    end

    always_ff @(posedge aclk) begin
        if (ld3) begin
            i3_reg    <= i_term;
            p3_reg    <= p2_reg;
            sp3_reg   <= sp2_reg;
            stop3_reg <= stop2_reg;
        end
    end

    // ---------------- stage 4: duty sum, clamp, output register ----------------
    logic signed [SUM_W-1:0] duty_sum  [NUM_WHEELS];
    logic [DUTY_W-1:0]       duty_calc [NUM_WHEELS];
    logic [DUTY_W-1:0]       duty_reg  [NUM_WHEELS];

    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            duty_sum[w] = signed'(SUM_W'(ff_offset_reg)) + signed'(SUM_W'(sp3_reg))
                        + SUM_W'(p3_reg[w]) + SUM_W'(i3_reg[w]);
            if (stop3_reg || duty_sum[w] < 0) begin
                duty_calc[w] = '0;
            end else if (duty_sum[w] > signed'(SUM_W'(duty_max_reg))) begin
                duty_calc[w] = duty_max_reg;
            end else begin
                duty_calc[w] = duty_sum[w][DUTY_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld4) begin
            duty_reg <= duty_calc;
        end
    end

    assign m_duty_w0 = duty_reg[0];
    assign m_duty_w1 = duty_reg[1];
    assign m_duty_w2 = duty_reg[2];
    assign m_duty_w3 = duty_reg[3];

    // ---------------- assertions ----------------
    // Input side only stalls when every stage holds an item.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v0_reg && v1_reg && v2_reg && v3_reg && m_valid_reg))
        else $error("input stalled with an empty pipeline stage");

    // A stop period clears the integrals; checked on the first and last wheels.
    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (ld2 && stop1_reg) |=> (integ_reg[0] == '0 && integ_reg[NUM_WHEELS-1] == '0))
        else $error("integral not cleared by zero setpoint");

    // Presented duties never exceed the configured maximum.
    a_duty_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (duty_reg[0] <= duty_max_reg && duty_reg[1] <= duty_max_reg
                      && duty_reg[2] <= duty_max_reg && duty_reg[3] <= duty_max_reg))
        else $error("duty above duty_max");

endmodule
